@@ sv/sss_pkg.sv @@
// Shared types and constants of the separator string splitter.
`timescale 1ns / 1ps

package sss_pkg;

    localparam int MAX_SEP_BYTES  = 8;
    localparam int OFFSET_BITS    = 16;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 64;
    localparam int SEP_LEN_BITS   = 4;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SEP_BYTES  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SEP_LENGTH = CFG_INDEX_BITS'(1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] seg_begin;
        logic [OFFSET_BITS-1:0] seg_end;
        logic                   last_segment;
        logic                   offset_overflow;
    } t_out_item;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    typedef struct packed {
        logic [1:0] n_items;
        t_out_item  first;
        t_out_item  second;
    } t_fifo_push;

endpackage

@@ sv/separator_string_splitter_core.sv @@
// Top level of the separator string splitter: window cell chain, offset tracking, result queue.
`timescale 1ns / 1ps
//
// Splits a byte stream into segments at non-overlapping occurrences of a separator
// of 1 to MAX_SEP_BYTES bytes. Input beats carry one byte and an end-of-string flag;
// output beats carry one segment (begin offset, end offset, last flag, overflow flag).
// The configuration channel writes the separator pattern (index 0) and its length
// (index 1); o_cfg_ready is always high. Write it only while no string is in flight.
// One input beat is taken per cycle while o_in_stall is low. The separator compare is done
// across the row of window cells in the same cycle as the byte arrives, so a byte never
// waits on the one before it. Segments are registered into a four-entry queue and leave it
// in order; a byte that ends both a separator and the string gives two beats.
// o_in_stall rises when the queue holds three or more segments, so a stalled receiver
// holds back the input after at most a few beats and nothing is dropped.
// Reset empties the queue and the window, zeroes all offsets, sets the separator to
// one zero byte, and lets the first byte in on the next cycle.
//
module separator_string_splitter_core
    import sss_pkg::*;
#(
    parameter int MAX_SEP_BYTES = sss_pkg::MAX_SEP_BYTES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_in_item                  i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out_item                 o_out_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam logic [SEP_LEN_BITS-1:0] MAX_LEN = SEP_LEN_BITS'(MAX_SEP_BYTES);
    localparam logic [OFFSET_BITS-1:0]  OFF_MAX = '1;

    logic [MAX_SEP_BYTES*8-1:0] r_sep_bytes;
    logic [SEP_LEN_BITS-1:0]    r_sep_len;
    logic [OFFSET_BITS-1:0]     r_pos;
    logic [OFFSET_BITS-1:0]     r_seg_start;
    logic                       r_ovf;

    logic [SEP_LEN_BITS-1:0]    eff_len;
    logic                       accept;
    logic                       match;
    logic                       eos;
    logic                       sat;
    logic                       ovf_now;
    logic [OFFSET_BITS-1:0]     end_off;
    logic [OFFSET_BITS-1:0]     sep_begin;
    logic [OFFSET_BITS-1:0]     n_seg_start;
    t_cell_ctrl                 cell_ctrl;
    t_fifo_push                 push;
    t_out_item                  match_item;
    t_out_item                  eos_item;
    logic [FIFO_CNT_BITS-1:0]   fifo_count;

    logic [7:0] cell_in_byte  [MAX_SEP_BYTES];
    logic       cell_in_valid [MAX_SEP_BYTES];
    logic [7:0] cell_byte     [MAX_SEP_BYTES];
    logic       cell_valid    [MAX_SEP_BYTES];
    logic [MAX_SEP_BYTES-1:0] cell_hit;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_bytes <= '0;
            r_sep_len   <= SEP_LEN_BITS'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SEP_BYTES:  r_sep_bytes <= i_cfg_data[MAX_SEP_BYTES*8-1:0];
                CFG_SEP_LENGTH: r_sep_len   <= i_cfg_data[SEP_LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_sep_len == '0) begin
            eff_len = SEP_LEN_BITS'(1);
        end else if (r_sep_len > MAX_LEN) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = r_sep_len;
        end
    end

    assign accept = i_in_valid && !o_in_stall;
    assign eos    = i_in_item.end_of_string;

    // Window cell row; the newest byte enters cell 0 and each cell hands its byte on.
    assign cell_ctrl.shift = accept;
    assign cell_ctrl.clear = match || eos;

    for (genvar j = 0; j < MAX_SEP_BYTES; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign cell_in_byte[j]  = i_in_item.data_byte;
            assign cell_in_valid[j] = 1'b1;
        end else begin : g_body
            assign cell_in_byte[j]  = cell_byte[j-1];
            assign cell_in_valid[j] = cell_valid[j-1];
        end

        sss_cell #(
            .MAX_SEP_BYTES (MAX_SEP_BYTES),
            .CELL_IDX      (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl),
            .i_byte  (cell_in_byte[j]),
            .i_valid (cell_in_valid[j]),
            .i_sep   (r_sep_bytes),
            .i_len   (eff_len),
            .o_byte  (cell_byte[j]),
            .o_valid (cell_valid[j]),
            .o_hit   (cell_hit[j])
        );
    end

    assign match = &cell_hit;

    // Offsets stick at the top of the range once the position saturates.
    assign sat     = r_pos == OFF_MAX;
    assign ovf_now = r_ovf || sat;
    assign end_off = sat ? OFF_MAX : r_pos + OFFSET_BITS'(1);

    always_comb begin
        if (end_off >= OFFSET_BITS'(eff_len)) begin
            sep_begin = end_off - OFFSET_BITS'(eff_len);
        end else begin
            sep_begin = '0;
        end
    end

    assign n_seg_start = match ? end_off : r_seg_start;

    always_comb begin
        match_item.seg_begin       = r_seg_start;
        match_item.seg_end         = (sep_begin < r_seg_start) ? r_seg_start : sep_begin;
        match_item.last_segment    = 1'b0;
        match_item.offset_overflow = ovf_now;
        eos_item.seg_begin         = n_seg_start;
        eos_item.seg_end           = end_off;
        eos_item.last_segment      = 1'b1;
        eos_item.offset_overflow   = ovf_now;
    end

    always_comb begin
        push.first   = match ? match_item : eos_item;
        push.second  = eos_item;
        push.n_items = 2'd0;
        if (accept) begin
            push.n_items = 2'(match) + 2'(eos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_seg_start <= '0;
            r_ovf       <= 1'b0;
        end else if (accept) begin
            if (eos) begin
                r_pos       <= '0;
                r_seg_start <= '0;
                r_ovf       <= 1'b0;
            end else begin
                r_pos       <= end_off;
                r_seg_start <= n_seg_start;
                r_ovf       <= ovf_now;
            end
        end
    end

    sss_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .o_count (fifo_count)
    );

    // Room for two more segments must remain before another byte is taken.
    assign o_in_stall = fifo_count > FIFO_CNT_BITS'(FIFO_DEPTH - 2);

endmodule

@@ sv/sss_cell.sv @@
// One window cell: holds one byte of the sliding window and compares it with the separator.
`timescale 1ns / 1ps

module sss_cell
    import sss_pkg::*;
#(
    parameter int MAX_SEP_BYTES = sss_pkg::MAX_SEP_BYTES,
    parameter int CELL_IDX      = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_ctrl                 i_ctrl,
    input  logic [7:0]                 i_byte,
    input  logic                       i_valid,
    input  logic [MAX_SEP_BYTES*8-1:0] i_sep,
    input  logic [SEP_LEN_BITS-1:0]    i_len,
    output logic [7:0]                 o_byte,
    output logic                       o_valid,
    output logic                       o_hit
);

    localparam logic [SEP_LEN_BITS:0] IDX = (SEP_LEN_BITS + 1)'(CELL_IDX);

    logic [7:0] r_byte;
    logic       r_valid;
    logic [7:0] sep_sel;
    logic       active;

    // This cell sees window byte CELL_IDX, which must equal separator byte len-1-CELL_IDX.
    always_comb begin
        sep_sel = '0;
        for (int k = 0; k < MAX_SEP_BYTES; k++) begin
            if ((SEP_LEN_BITS + 1)'(k) + IDX + (SEP_LEN_BITS + 1)'(1) == {1'b0, i_len}) begin
                sep_sel = i_sep[8*k +: 8];
            end
        end
    end

    assign active = IDX < {1'b0, i_len};
    assign o_hit  = !active || (i_valid && (sep_sel == i_byte));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_ctrl.clear ? 1'b0 : i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

@@ sv/sss_out_fifo.sv @@
// Small result queue that takes up to two segments per cycle and hands out one per cycle unless stalled.
`timescale 1ns / 1ps

module sss_out_fifo
    import sss_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_fifo_push               i_push,
    input  logic                     i_stall,
    output logic                     o_valid,
    output t_out_item                o_item,
    output logic [FIFO_CNT_BITS-1:0] o_count
);

    t_out_item                mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;
    logic [FIFO_CNT_BITS-1:0] n_count;
    logic                     pop;

    assign pop = (r_count != '0) && !i_stall;

    always_comb begin
        n_count = r_count + FIFO_CNT_BITS'(i_push.n_items);
        if (pop) begin
            n_count = n_count - FIFO_CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_BITS'(i_push.n_items);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_BITS'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n_items != 2'd0) begin
            mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.n_items == 2'd2) begin
            mem[r_wr_ptr + FIFO_PTR_BITS'(1)] <= i_push.second;
        end
    end

    assign o_valid = r_count != '0;
    assign o_item  = mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

@@ sv/sss_checker.sv @@
// Port-level checks for the separator string splitter, bound to the top level.
`timescale 1ns / 1ps

module sss_checker
    import sss_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A stalled output beat stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output beat changed while stalled");

    // Reset leaves no segment pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

    // A segment never ends before it begins.
    a_seg_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.seg_begin <= o_out_item.seg_end)
        else $error("segment end below segment begin");

    // With the queue empty the input side must be open.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with no segment queued");

endmodule

bind separator_string_splitter_core sss_checker u_sss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

@@ verif/separator_string_splitter_core_test.sv @@
// Self-checking testbench of the separator string splitter core.
`timescale 1ns / 1ps

module separator_string_splitter_core_test;
    import sss_pkg::*;

    localparam int unsigned OFF_MAX          = (1 << OFFSET_BITS) - 1;
    localparam int unsigned CYCLE_LIMIT      = 40000;
    localparam int unsigned DRAIN_CYCLES     = 8;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned PHASE_BYTES      = 85;

    logic                      i_clk       = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    t_in_item                  in_item     = '0;
    logic                      out_stall   = 1'b0;
    logic                      cfg_valid   = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data    = '0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    t_out_item                 o_out_item;
    logic                      o_cfg_ready;

    // Separator as currently programmed, and the per-string scan state.
    logic [63:0]               sep_pattern      = '0;
    logic [SEP_LEN_BITS-1:0]   sep_len_reg      = SEP_LEN_BITS'(1);
    logic [63:0]               recent_bytes     = '0;
    int unsigned               recent_count     = 0;
    int unsigned               next_offset      = 0;
    int unsigned               segment_origin   = 0;
    bit                        offset_saturated = 1'b0;

    t_out_item                 expected_segments[$];

    int unsigned               fail_count       = 0;
    int unsigned               cycle_count      = 0;
    int unsigned               bytes_sent       = 0;
    int unsigned               strings_sent     = 0;
    int unsigned               segments_checked = 0;
    int unsigned               settings_used    = 0;
    int unsigned               burst_left       = 0;
    int unsigned               gap_max          = 0;
    int unsigned               stall_pct        = 0;
    int unsigned               hold_requests    = 0;

    separator_string_splitter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int unsigned active_sep_len();
        int unsigned len;
        len = sep_len_reg;
        if (len == 0) len = 1;
        if (len > MAX_SEP_BYTES) len = MAX_SEP_BYTES;
        return len;
    endfunction

    function automatic void queue_segment(int unsigned b, int unsigned e, bit last);
        t_out_item seg;
        if (e < b) e = b;
        seg.seg_begin       = OFFSET_BITS'(b);
        seg.seg_end         = OFFSET_BITS'(e);
        seg.last_segment    = last;
        seg.offset_overflow = offset_saturated;
        expected_segments.push_back(seg);
    endfunction

    function automatic void clear_scan();
        recent_bytes     = '0;
        recent_count     = 0;
        next_offset      = 0;
        segment_origin   = 0;
        offset_saturated = 1'b0;
    endfunction

    // Advances the scan state by one accepted byte and queues the segments it closes.
    function automatic void scan_byte(t_in_item item);
        int unsigned len, end_off;
        bit          hit;
        len = active_sep_len();
        if (next_offset >= OFF_MAX) begin
            offset_saturated = 1'b1;
            end_off = OFF_MAX;
        end else begin
            end_off = next_offset + 1;
        end
        recent_bytes = {recent_bytes[55:0], item.data_byte};
        if (recent_count < MAX_SEP_BYTES) recent_count++;
        hit = (recent_count >= len);
        for (int k = 0; k < len; k++) begin
            if (sep_pattern[8*k +: 8] != recent_bytes[8*(len-1-k) +: 8]) hit = 1'b0;
        end
        if (hit) begin
            queue_segment(segment_origin, (end_off >= len) ? end_off - len : 0, 1'b0);
            segment_origin = end_off;
            recent_bytes   = '0;
            recent_count   = 0;
        end
        next_offset = end_off;
        if (item.end_of_string) begin
            queue_segment(segment_origin, end_off, 1'b1);
            clear_scan();
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_segments.size() == 0) begin
                $error("segment beat with nothing expected: begin %0d end %0d",
                       o_out_item.seg_begin, o_out_item.seg_end);
                fail_count++;
            end else begin
                want = expected_segments.pop_front();
                check_field("seg_begin", want.seg_begin, o_out_item.seg_begin);
                check_field("seg_end", want.seg_end, o_out_item.seg_end);
                check_field("last_segment", want.last_segment, o_out_item.last_segment);
                check_field("offset_overflow", want.offset_overflow,
                            o_out_item.offset_overflow);
                segments_checked++;
            end
        end
    end

    // Output side: random stall runs, or a long hold-off whenever one is requested.
    initial begin : receiver
        int unsigned run_left;
        int unsigned holds_done;
        bit          level;
        run_left   = 0;
        holds_done = 0;
        level      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_done) begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                out_stall <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 12);
                    level    = ($urandom_range(0, 99) < stall_pct);
                end
                run_left--;
                out_stall <= level;
            end
        end
    end

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_segments.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_separator(input logic [63:0] pattern, input logic [3:0] len);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SEP_BYTES;
        cfg_data  <= pattern;
        do @(posedge i_clk); while (!o_cfg_ready);
        sep_pattern = pattern;
        cfg_index <= CFG_SEP_LENGTH;
        cfg_data  <= CFG_DATA_BITS'(len);
        do @(posedge i_clk); while (!o_cfg_ready);
        sep_len_reg = len;
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Sends one byte beat; the sender pauses between bursts of random length when gap_max is nonzero.
    task automatic offer_byte(input logic [7:0] data, input logic eos);
        t_in_item item;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gap_max > 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            end
        end
        burst_left--;
        item.data_byte     = data;
        item.end_of_string = eos;
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge i_clk); while (o_in_stall);
        scan_byte(item);
        bytes_sent++;
        if (eos) strings_sent++;
    endtask

    task automatic send_text(input logic [7:0] text[$]);
        foreach (text[i]) offer_byte(text[i], i == text.size() - 1);
    endtask

    // Mostly separators, partial separators and short runs of filler; now and then pure noise.
    task automatic send_random_string();
        logic [7:0]  text[$];
        int unsigned target, len, n;
        len    = active_sep_len();
        target = $urandom_range(1, 24);
        if ($urandom_range(0, 9) == 0) begin
            repeat (target) text.push_back(8'($urandom));
        end else begin
            while (text.size() < target) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        for (int k = 0; k < len; k++) text.push_back(sep_pattern[8*k +: 8]);
                    end
                    5, 6: begin
                        n = $urandom_range(1, len);
                        for (int k = 0; k < n; k++) text.push_back(sep_pattern[8*k +: 8]);
                    end
                    default: begin
                        repeat ($urandom_range(1, 3)) text.push_back(8'($urandom));
                    end
                endcase
            end
        end
        send_text(text);
    endtask

    // Reset leaves a single zero byte as separator.
    task automatic test_reset_defaults();
        send_text('{8'h00});
        send_text('{8'hFF, 8'h7F});
    endtask

    task automatic test_length_limits();
        // A length of zero acts as one, so only the low byte of the pattern counts.
        set_separator(64'hAB12_34CD_EF56_78FF, 4'd0);
        send_text('{8'h12, 8'hFF, 8'h34});
        // An oversized length acts as the full eight bytes.
        set_separator(64'h0807_0605_0403_0201, 4'd15);
        send_text('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08});
        // Upper pattern bytes are ignored, and a run of three takes only one match.
        set_separator(64'hDEAD_BEEF_0000_6161, 4'd2);
        send_text('{8'h61, 8'h61, 8'h61, 8'h62});
    endtask

    task automatic test_random_strings();
        int unsigned start;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0:       set_separator('1, 4'd8);
                1:       set_separator('0, 4'd1);
                2:       set_separator({$urandom, $urandom}, 4'd0);
                3:       set_separator({$urandom, $urandom}, 4'd15);
                default: set_separator({$urandom, $urandom}, 4'($urandom_range(1, 8)));
            endcase
            if (phase % 3 == 0) begin
                stall_pct <= 0;
                gap_max = 0;
            end else begin
                stall_pct <= $urandom_range(10, 60);
                gap_max = $urandom_range(1, 8);
            end
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) send_random_string();
        end
    endtask

    // The receiver holds off while the sender keeps going, so the queue fills up.
    task automatic test_output_backpressure();
        int unsigned start;
        set_separator(64'h2C, 4'd1);
        stall_pct <= 0;
        gap_max = 0;
        hold_requests <= hold_requests + 1;
        start = bytes_sent;
        while (bytes_sent - start < 60) send_random_string();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_length_limits();
        test_random_strings();
        test_output_backpressure();
        drain_pipeline();
        $display("Sent %0d bytes in %0d strings over %0d separator settings.",
                 bytes_sent, strings_sent, settings_used);
        $display("Checked %0d segments, including a long receiver hold-off that filled the queue.",
                 segments_checked);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
